### rtl/spq_pkg.sv
package spq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PRIO_BITS   = 16;
    localparam int TAG_BITS    = 16;
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req_type;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [PRIO_BITS-1:0] new_prio;
        logic [TAG_BITS-1:0]  new_tag;
    } t_req;

    typedef struct packed {
        logic                 ok;
        logic                 top_valid;
        logic [PRIO_BITS-1:0] top_prio;
        logic [TAG_BITS-1:0]  top_tag;
        logic [CNT_BITS-1:0]  occupancy;
        logic                 is_full;
        logic                 is_empty;
    } t_rsp;

    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [TAG_BITS-1:0]  tag;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry ent;
    } t_cell_cmd;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   lt;
        t_entry ent;
    } t_link;

endpackage

### rtl/spq_cell.sv
module spq_cell
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_cmd i_cmd,
    input  t_link     i_left,
    input  t_link     i_right,
    output t_link     o_link
);

    logic   r_valid;
    logic   n_valid;
    t_entry r_ent;
    t_entry n_ent;
    logic   w_lt;

    // own entry ranks below the new one and moves away from the head
    assign w_lt = r_valid && (r_ent.prio < i_cmd.ent.prio);

    always_comb begin
        n_valid = r_valid;
        n_ent   = r_ent;
        if (i_cmd.ins) begin
            n_valid = i_left.valid;
            if (i_left.lt) begin
                n_ent = i_left.ent;
            end else if (w_lt || (!r_valid && i_left.valid)) begin
                n_ent = i_cmd.ent;
            end
        end else if (i_cmd.rem) begin
            n_valid = i_right.valid;
            n_ent   = i_right.ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    assign o_link.valid = r_valid;
    assign o_link.lt    = w_lt;
    assign o_link.ent   = r_ent;

endmodule

### rtl/sorted_priority_queue_core.sv
// channel | valid       | ready       | payload
// request | i_in_valid  | o_in_ready  | i_in_data  (t_req)
// result  | o_out_valid | i_out_ready | o_out_data (t_rsp)
//
// one request per cycle; its result appears in the output register on the next cycle
// the rate is set by the cell row: all cells compare and shift in the same cycle
// reset (synchronous, active low) empties the queue and the output register
// a request is taken whenever the output register is empty or drained in the same cycle
// a stalled result holds its value; requests wait behind it
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_data
);

    // cells hold entries in descending priority order, the top entry in cell 0
    t_link               w_link [QUEUE_DEPTH];
    t_link               w_left [QUEUE_DEPTH];
    t_link               w_right[QUEUE_DEPTH];
    t_cell_cmd           w_cmd;

    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;
    logic                r_out_valid;
    logic                n_out_valid;
    t_rsp                r_out;
    t_rsp                n_out;

    logic                w_xfer;
    logic                w_full;
    logic                w_empty;
    logic                w_ok;
    t_entry              w_head;
    logic                w_head_valid;

    assign w_full  = w_link[QUEUE_DEPTH-1].valid;
    assign w_empty = !w_link[0].valid;

    // output register is free or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_xfer     = i_in_valid && o_in_ready;

    // decode the request; unused codes behave as a query
    always_comb begin
        w_cmd.ins = 1'b0;
        w_cmd.rem = 1'b0;
        w_cmd.ent.prio = i_in_data.new_prio;
        w_cmd.ent.tag  = i_in_data.new_tag;
        unique case (i_in_data.req_type)
            REQ_INSERT: begin
                w_ok      = !w_full;
                w_cmd.ins = w_xfer && !w_full;
            end
            REQ_REMOVE: begin
                w_ok      = !w_empty;
                w_cmd.rem = w_xfer && !w_empty;
            end
            default: begin
                w_ok = !w_empty;
            end
        endcase
    end

    // row of cells, each linked to both neighbors
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            // the head sees an always-occupied slot that never gives way
            assign w_left[g] = '{valid: 1'b1, lt: 1'b0, ent: '0};
        end else begin : g_mid
            assign w_left[g] = w_link[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right[g] = '{valid: 1'b0, lt: 1'b0, ent: '0};
        end else begin : g_body
            assign w_right[g] = w_link[g+1];
        end

        spq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_link  (w_link[g])
        );
    end

    // head entry after the operation, mirrors what cell 0 loads
    always_comb begin
        w_head       = w_link[0].ent;
        w_head_valid = w_link[0].valid;
        if (w_cmd.ins) begin
            w_head_valid = 1'b1;
            if (w_link[0].lt || !w_link[0].valid) begin
                w_head = w_cmd.ent;
            end
        end else if (w_cmd.rem) begin
            w_head       = w_right[0].ent;
            w_head_valid = w_right[0].valid;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (w_cmd.rem) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    // result is the state after the operation
    always_comb begin
        n_out.ok        = w_ok;
        n_out.top_valid = w_head_valid;
        n_out.top_prio  = w_head_valid ? w_head.prio : '0;
        n_out.top_tag   = w_head_valid ? w_head.tag : '0;
        n_out.occupancy = n_count;
        n_out.is_full   = (n_count == CNT_BITS'(QUEUE_DEPTH));
        n_out.is_empty  = !w_head_valid;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_xfer) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload loads only on a request transfer
    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/spq_checker.sv
module spq_core_props
    import spq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_req i_in_data,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_data
);

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // every request transfer yields a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("request transfer without result");

    // flags agree with the count
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.occupancy == '0)) &&
        (o_out_data.is_full == (o_out_data.occupancy == CNT_BITS'(QUEUE_DEPTH))) &&
        (o_out_data.top_valid == !o_out_data.is_empty))
        else $error("result flags disagree with occupancy");

    // an empty queue reports a zero top entry
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.top_valid |->
        (o_out_data.top_prio == '0) && (o_out_data.top_tag == '0))
        else $error("empty queue with nonzero top entry");

endmodule

bind sorted_priority_queue_core spq_core_props u_spq_core_props (.*);

### verif/spq_checker.sv
// watches both channels, keeps a shadow of the sorted queue and compares every result
module spq_checker
    import spq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_req i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_rsp i_out_data,
    output int   o_mismatches,
    output int   o_outstanding
);

    // ascending order, top entry at shadow_count-1
    logic [PRIO_BITS-1:0] shadow_prio [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]  shadow_tag  [QUEUE_DEPTH];
    int                   shadow_count = 0;
    t_rsp                 expected_rsps [$];
    int                   mismatches   = 0;
    int                   waiting      = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = waiting;

    function automatic t_rsp serve_request(input t_req req);
        t_rsp rsp;
        int   pos;
        logic done;
        rsp  = '0;
        done = 1'b0;
        case (req.req_type)
            REQ_INSERT: begin
                if (shadow_count < QUEUE_DEPTH) begin
                    // equal priorities stay above the newcomer
                    pos = shadow_count;
                    while (pos > 0 && shadow_prio[pos-1] >= req.new_prio) begin
                        shadow_prio[pos] = shadow_prio[pos-1];
                        shadow_tag[pos]  = shadow_tag[pos-1];
                        pos--;
                    end
                    shadow_prio[pos] = req.new_prio;
                    shadow_tag[pos]  = req.new_tag;
                    shadow_count++;
                    done = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (shadow_count > 0) begin
                    shadow_count--;
                    done = 1'b1;
                end
            end
            // query, and the spare code behaves as one
            default: done = shadow_count > 0;
        endcase
        rsp.ok        = done;
        rsp.top_valid = shadow_count > 0;
        if (shadow_count > 0) begin
            rsp.top_prio = shadow_prio[shadow_count-1];
            rsp.top_tag  = shadow_tag[shadow_count-1];
        end
        rsp.occupancy = CNT_BITS'(shadow_count);
        rsp.is_full   = shadow_count == QUEUE_DEPTH;
        rsp.is_empty  = shadow_count == 0;
        return rsp;
    endfunction

    task automatic note_mismatch(input string what, input t_rsp want, input t_rsp got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] result mismatch (%s)", $time, what);
            $display("    expected ok=%0b tv=%0b prio=%h tag=%h occ=%0d full=%0b empty=%0b",
                     want.ok, want.top_valid, want.top_prio, want.top_tag, want.occupancy,
                     want.is_full, want.is_empty);
            $display("    actual   ok=%0b tv=%0b prio=%h tag=%h occ=%0d full=%0b empty=%0b",
                     got.ok, got.top_valid, got.top_prio, got.top_tag, got.occupancy,
                     got.is_full, got.is_empty);
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp  want;
        string diffs;
        if (!i_rst_n) begin
            shadow_count = 0;
            expected_rsps.delete();
        end else begin
            // result side first: a result leaving now belongs to an older request
            if (i_out_valid && i_out_ready) begin
                if (expected_rsps.size() == 0) begin
                    note_mismatch("no result expected", '0, i_out_data);
                end else begin
                    want  = expected_rsps.pop_front();
                    diffs = "";
                    if (want.ok !== i_out_data.ok)               diffs = {diffs, " ok"};
                    if (want.top_valid !== i_out_data.top_valid) diffs = {diffs, " top_valid"};
                    if (want.top_prio !== i_out_data.top_prio)   diffs = {diffs, " top_prio"};
                    if (want.top_tag !== i_out_data.top_tag)     diffs = {diffs, " top_tag"};
                    if (want.occupancy !== i_out_data.occupancy) diffs = {diffs, " occupancy"};
                    if (want.is_full !== i_out_data.is_full)     diffs = {diffs, " is_full"};
                    if (want.is_empty !== i_out_data.is_empty)   diffs = {diffs, " is_empty"};
                    if (diffs != "") note_mismatch({"field", diffs}, want, i_out_data);
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_rsps.push_back(serve_request(i_in_data));
            end
        end
        waiting = expected_rsps.size();
    end

endmodule

### verif/testbench.sv
// stimulus and verdict for the sorted priority queue; result comparison lives in spq_checker
module testbench;
    import spq_pkg::*;

    // request code the block treats as a query
    localparam logic [1:0] REQ_SPARE    = 2'd3;
    localparam int         RANDOM_ITEMS = 800;
    // no idling on either side once this many random items went out
    localparam int         CALM_AFTER   = 700;
    // long receiver hold-off that backs the block up into its input
    localparam int         HOLD_AT      = 300;
    localparam int         HOLD_CYCLES  = 60;

    logic i_clk      = 1'b0;
    logic i_rst_n    = 1'b0;
    logic in_valid   = 1'b0;
    t_req in_data    = '0;
    logic out_ready  = 1'b0;
    logic in_ready;
    logic out_valid;
    t_rsp out_data;
    int   mismatches;
    int   outstanding;

    // shared between the sender and the receiver
    int   n_sent = 0;
    logic calm   = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_priority_queue_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    spq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic t_req compose(input logic [1:0] kind, input logic [PRIO_BITS-1:0] prio,
                                     input logic [TAG_BITS-1:0] tag);
        t_req req;
        req.req_type = kind;
        req.new_prio = prio;
        req.new_tag  = tag;
        return req;
    endfunction

    // offer one request and hold it until the transfer happens
    task automatic send(input t_req req);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (!in_ready);
        n_sent++;
    endtask

    // priorities crowd onto a few values so ties are common, with extremes mixed in
    function automatic logic [PRIO_BITS-1:0] pick_prio();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)       return PRIO_BITS'($urandom_range(0, 7));
        else if (roll == 5) return '0;
        else if (roll == 6) return '1;
        else                return PRIO_BITS'($urandom);
    endfunction

    // receiver: random stalls, one long hold-off, then steady acceptance
    initial begin
        logic held;
        held = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!held && n_sent >= HOLD_AT) begin
                // sender keeps offering; the output register stays full and input stalls
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // sender: reset, directed requests, random phases, drain, verdict
    initial begin
        int                   mode;
        int                   run_left;
        int                   roll;
        int                   ins_pct;
        int                   rem_pct;
        logic [1:0]           kind;
        logic [PRIO_BITS-1:0] prio;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue: query, remove and the spare code all report nothing
        send(compose(REQ_QUERY, '0, '0));
        send(compose(REQ_REMOVE, '1, '1));
        send(compose(REQ_SPARE, '0, '0));
        // field extremes
        send(compose(REQ_INSERT, '0, '1));
        send(compose(REQ_INSERT, '1, '0));
        send(compose(REQ_INSERT, 16'h8000, 16'h1234));
        // equal to the top: the earlier entry stays on top
        send(compose(REQ_INSERT, '1, 16'hAAAA));
        send(compose(REQ_QUERY, 16'h5555, 16'hAAAA));
        send(compose(REQ_SPARE, '1, '1));
        send(compose(REQ_REMOVE, '0, '0));
        // fill to the brim with repeated priorities, then one insert too many
        for (int i = 0; i < 13; i++) begin
            send(compose(REQ_INSERT, PRIO_BITS'(16'h1000 * (i % 5)), TAG_BITS'(16'hC000 + i)));
        end
        send(compose(REQ_INSERT, '1, 16'h0BAD));
        send(compose(REQ_QUERY, '0, '0));

        // random phases lean toward filling, draining or neither
        mode     = 0;
        run_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == CALM_AFTER) calm = 1'b1;
            if (run_left == 0) begin
                mode     = $urandom_range(0, 2);
                run_left = $urandom_range(20, 40);
            end
            run_left--;
            case (mode)
                0:       begin ins_pct = 70; rem_pct = 20; end
                1:       begin ins_pct = 20; rem_pct = 70; end
                default: begin ins_pct = 45; rem_pct = 45; end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)                kind = REQ_INSERT;
            else if (roll < ins_pct + rem_pct) kind = REQ_REMOVE;
            else if (roll[0])                  kind = REQ_QUERY;
            else                               kind = REQ_SPARE;
            prio = pick_prio();
            send(compose(kind, prio, TAG_BITS'($urandom)));
        end
        in_valid <= 1'b0;

        // wait out every expected result, then keep watching for strays
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("** sorted_priority_queue_core: PASSED **");
        end else begin
            $display("** sorted_priority_queue_core: FAILED **");
        end
        $finish;
    end

    // far beyond the slowest correct run
    initial begin
        #4000000;
        $display("** sorted_priority_queue_core: FAILED **");
        $finish;
    end

endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_checker.sv
verif/spq_checker.sv
verif/testbench.sv
